### hdl/toaf_pkg.sv
// ----------------------------------------------------------------------------
// toaf_pkg
// Shared types and constants for the two-operand ALU: opcodes and the
// payloads carried between pipeline stages.
// ----------------------------------------------------------------------------
package toaf_pkg;

  localparam int unsigned DataW = 16;

  localparam logic [DataW-1:0] MaskByte = 16'h00ff;
  localparam logic [DataW-1:0] MaskWord = 16'hffff;

  typedef enum logic [3:0] {
    OPC_MOV  = 4'd4,
    OPC_ADD  = 4'd5,
    OPC_ADDC = 4'd6,
    OPC_SUBC = 4'd7,
    OPC_SUB  = 4'd8,
    OPC_CMP  = 4'd9,
    OPC_DADD = 4'd10,
    OPC_BIT  = 4'd11,
    OPC_BIC  = 4'd12,
    OPC_BIS  = 4'd13,
    OPC_XOR  = 4'd14,
    OPC_AND  = 4'd15
  } opc_t;

  // request as it arrives on the input channel
  typedef struct packed {
    logic [3:0]       req_type;
    logic             byte_mode;
    logic [DataW-1:0] src_value;
    logic [DataW-1:0] dst_value;
    logic             carry_in;
  } req_t;

  // decode stage -> execute stage
  typedef struct packed {
    logic [3:0]       op;
    logic             byte_mode;
    logic [DataW-1:0] s;      // masked source
    logic [DataW-1:0] d;      // masked destination
    logic [DataW-1:0] add_a;  // adder operand, source inverted for subtraction
    logic             add_c;  // adder / decimal carry in
  } dec_t;

  // execute stage -> flag stage
  typedef struct packed {
    logic [3:0]       op;
    logic             byte_mode;
    logic [DataW-1:0] r;      // raw result, not yet masked
    logic             c_ar;   // carry from binary or decimal adder
    logic             a_sgn;  // adder operand signs
    logic             b_sgn;
    logic             sd_sgn; // both source and destination negative
  } exe_t;

  // result item
  typedef struct packed {
    logic [DataW-1:0] result;
    logic             flag_negative;
    logic             flag_zero;
    logic             flag_carry;
    logic             flag_overflow;
    logic             flags_updated;
    logic             write_result;
  } res_t;

endpackage

### hdl/toaf_if.sv
// ----------------------------------------------------------------------------
// toaf_in_if / toaf_out_if
// Valid/ready channels for ALU requests and results.
// ----------------------------------------------------------------------------
interface toaf_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic        byte_mode;
  logic [15:0] src_value;
  logic [15:0] dst_value;
  logic        carry_in;

  modport source (output valid, req_type, byte_mode, src_value, dst_value, carry_in,
                  input ready);
  modport sink   (input valid, req_type, byte_mode, src_value, dst_value, carry_in,
                  output ready);
endinterface

interface toaf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result;
  logic        flag_negative;
  logic        flag_zero;
  logic        flag_carry;
  logic        flag_overflow;
  logic        flags_updated;
  logic        write_result;

  modport source (output valid, result, flag_negative, flag_zero, flag_carry,
                  flag_overflow, flags_updated, write_result, input ready);
  modport sink   (input valid, result, flag_negative, flag_zero, flag_carry,
                  flag_overflow, flags_updated, write_result, output ready);
endinterface

### hdl/toaf_dec.sv
// ----------------------------------------------------------------------------
// toaf_dec
// First stage: masks the operands to the operating width and prepares the
// adder operand and carry for the opcode.
// ----------------------------------------------------------------------------
module toaf_dec (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  toaf_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_ready,
  output toaf_pkg::dec_t out_dec
);
  import toaf_pkg::*;

  logic             valid_r;
  dec_t             dec_r, dec_nxt;
  logic [DataW-1:0] mask;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    mask              = in_req.byte_mode ? MaskByte : MaskWord;
    dec_nxt.op        = in_req.req_type;
    dec_nxt.byte_mode = in_req.byte_mode;
    dec_nxt.s         = in_req.src_value & mask;
    dec_nxt.d         = in_req.dst_value & mask;
    dec_nxt.add_a     = in_req.src_value & mask;
    dec_nxt.add_c     = 1'b0;
    case (opc_t'(in_req.req_type))
      OPC_ADDC, OPC_DADD: dec_nxt.add_c = in_req.carry_in;
      OPC_SUBC: begin
        dec_nxt.add_a = ~in_req.src_value & mask;
        dec_nxt.add_c = in_req.carry_in;
      end
      OPC_SUB, OPC_CMP: begin
        dec_nxt.add_a = ~in_req.src_value & mask;
        dec_nxt.add_c = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dec_r <= dec_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_dec   = dec_r;

endmodule

### hdl/toaf_exe.sv
// ----------------------------------------------------------------------------
// toaf_exe
// Second stage: binary adder, four-digit decimal adder and logic unit, with
// the result picked by opcode.
// ----------------------------------------------------------------------------
module toaf_exe (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  toaf_pkg::dec_t in_dec,
  output logic           out_valid,
  input  logic           out_ready,
  output toaf_pkg::exe_t out_exe
);
  import toaf_pkg::*;

  localparam int unsigned NDig = DataW / 4;

  logic             valid_r;
  exe_t             exe_r, exe_nxt;
  logic [DataW:0]   sum;
  logic             add_cy;
  logic [DataW-1:0] bcd;
  logic             bcd_cy;
  logic [NDig:0]    dcy;
  logic [4:0]       dsum;

  assign in_ready = !valid_r || out_ready;

  // binary add; operands are already masked so byte carry lands in bit 8
  always_comb begin
    sum    = {1'b0, in_dec.add_a} + {1'b0, in_dec.d} + {{DataW{1'b0}}, in_dec.add_c};
    add_cy = in_dec.byte_mode ? sum[8] : sum[DataW];
  end

  // decimal add, digit by digit; a digit of ten or more wraps and carries
  always_comb begin
    bcd    = '0;
    dcy    = '0;
    dcy[0] = in_dec.add_c;
    for (int i = 0; i < NDig; i++) begin
      dsum = {1'b0, in_dec.s[4*i +: 4]} + {1'b0, in_dec.d[4*i +: 4]} + {4'd0, dcy[i]};
      if (dsum >= 5'd10) begin
        dsum     = dsum - 5'd10;
        dcy[i+1] = 1'b1;
      end else begin
        dcy[i+1] = 1'b0;
      end
      bcd[4*i +: 4] = dsum[3:0];
    end
    bcd_cy = in_dec.byte_mode ? dcy[2] : dcy[NDig];
  end

  always_comb begin
    exe_nxt.op        = in_dec.op;
    exe_nxt.byte_mode = in_dec.byte_mode;
    exe_nxt.c_ar      = add_cy;
    exe_nxt.a_sgn     = in_dec.byte_mode ? in_dec.add_a[7] : in_dec.add_a[DataW-1];
    exe_nxt.b_sgn     = in_dec.byte_mode ? in_dec.d[7] : in_dec.d[DataW-1];
    exe_nxt.sd_sgn    = exe_nxt.b_sgn &
                        (in_dec.byte_mode ? in_dec.s[7] : in_dec.s[DataW-1]);
    case (opc_t'(in_dec.op))
      OPC_MOV: exe_nxt.r = in_dec.s;
      OPC_ADD, OPC_ADDC, OPC_SUBC, OPC_SUB, OPC_CMP: exe_nxt.r = sum[DataW-1:0];
      OPC_DADD: begin
        exe_nxt.r    = bcd;
        exe_nxt.c_ar = bcd_cy;
      end
      OPC_BIT, OPC_AND: exe_nxt.r = in_dec.s & in_dec.d;
      OPC_BIC:          exe_nxt.r = ~in_dec.s & in_dec.d;
      OPC_BIS:          exe_nxt.r = in_dec.s | in_dec.d;
      OPC_XOR:          exe_nxt.r = in_dec.s ^ in_dec.d;
      default:          exe_nxt.r = in_dec.d;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      exe_r <= exe_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_exe   = exe_r;

endmodule

### hdl/toaf_flg.sv
// ----------------------------------------------------------------------------
// toaf_flg
// Third stage: masks the result and forms N, Z, C, V plus the update and
// write-back marks. Its register is the output register of the block.
// ----------------------------------------------------------------------------
module toaf_flg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  toaf_pkg::exe_t in_exe,
  output logic           out_valid,
  input  logic           out_ready,
  output toaf_pkg::res_t out_res
);
  import toaf_pkg::*;

  logic             valid_r;
  res_t             res_r, res_nxt;
  logic [DataW-1:0] r;
  logic             r_sgn;
  logic             r_nz;
  logic             ovf;
  logic             c;
  logic             v;
  logic             upd;
  logic             wr;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    r     = in_exe.r & (in_exe.byte_mode ? MaskByte : MaskWord);
    r_sgn = in_exe.byte_mode ? r[7] : r[DataW-1];
    r_nz  = |r;
    ovf   = (in_exe.a_sgn ^ r_sgn) & (in_exe.b_sgn ^ r_sgn);
    c     = 1'b0;
    v     = 1'b0;
    upd   = 1'b1;
    wr    = 1'b1;
    case (opc_t'(in_exe.op))
      OPC_MOV, OPC_BIC, OPC_BIS: upd = 1'b0;
      OPC_ADD, OPC_ADDC, OPC_SUBC, OPC_SUB: begin
        c = in_exe.c_ar;
        v = ovf;
      end
      OPC_CMP: begin
        c  = in_exe.c_ar;
        v  = ovf;
        wr = 1'b0;
      end
      OPC_DADD: c = in_exe.c_ar;
      OPC_BIT: begin
        c  = r_nz;
        wr = 1'b0;
      end
      OPC_XOR: begin
        c = r_nz;
        v = in_exe.sd_sgn;
      end
      OPC_AND: c = r_nz;
      default: begin
        // opcodes below MOV do nothing
        upd = 1'b0;
        wr  = 1'b0;
      end
    endcase
    res_nxt.result        = r;
    res_nxt.flag_negative = upd & r_sgn;
    res_nxt.flag_zero     = upd & !r_nz;
    res_nxt.flag_carry    = upd & c;
    res_nxt.flag_overflow = upd & v;
    res_nxt.flags_updated = upd;
    res_nxt.write_result  = wr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### hdl/two_operand_alu_with_flags_core.sv
// ----------------------------------------------------------------------------
// two_operand_alu_with_flags_core
// Double-operand ALU of a 16-bit microcontroller execute stage, with flags.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one instruction per transfer: opcode, byte/word mode,
//   source and destination operands and the current carry. out_ch returns
//   one result per instruction: masked result, N/Z/C/V, whether the flags
//   change and whether the result is written back.
//   Three register stages: decode, execute (binary/decimal adder, logic),
//   flags. The flag stage register drives out_ch directly.
//   An instruction passes the decode, execute and flag registers on its way; one
//   instruction is taken every cycle while out_ch keeps taking results.
//   Each stage holds its item while the stage after it is full and stalled,
//   so a stall on out_ch backs up one stage at a time; in_ch.ready drops
//   only once all three stages are full. Nothing is lost or repeated.
//   Reset (rst_n low, synchronous) empties all stages; there is no state
//   beyond the items in flight.
// ----------------------------------------------------------------------------
module two_operand_alu_with_flags_core (
  input  logic        clk,
  input  logic        rst_n,
  toaf_in_if.sink     in_ch,
  toaf_out_if.source  out_ch
);
  import toaf_pkg::*;

  req_t req;
  dec_t dec;
  exe_t exe;
  res_t res;
  logic dec_valid, dec_ready;
  logic exe_valid, exe_ready;

  always_comb begin
    req.req_type  = in_ch.req_type;
    req.byte_mode = in_ch.byte_mode;
    req.src_value = in_ch.src_value;
    req.dst_value = in_ch.dst_value;
    req.carry_in  = in_ch.carry_in;
  end

  toaf_dec u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_req    (req),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_dec   (dec)
  );

  toaf_exe u_exe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_dec    (dec),
    .out_valid (exe_valid),
    .out_ready (exe_ready),
    .out_exe   (exe)
  );

  toaf_flg u_flg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (exe_valid),
    .in_ready  (exe_ready),
    .in_exe    (exe),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.result        = res.result;
  assign out_ch.flag_negative = res.flag_negative;
  assign out_ch.flag_zero     = res.flag_zero;
  assign out_ch.flag_carry    = res.flag_carry;
  assign out_ch.flag_overflow = res.flag_overflow;
  assign out_ch.flags_updated = res.flags_updated;
  assign out_ch.write_result  = res.write_result;

  // input is only held off when every stage is occupied
  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (dec_valid && exe_valid && out_ch.valid && !out_ch.ready))
    else $error("input stalled with an empty stage");

  // flags stay clear when not updated
  a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.flags_updated) |->
      (!out_ch.flag_negative && !out_ch.flag_zero &&
       !out_ch.flag_carry && !out_ch.flag_overflow))
    else $error("flags set on an instruction that keeps them");

  // zero flag agrees with the result
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.flags_updated) |->
      (out_ch.flag_zero == (out_ch.result == 16'd0)))
    else $error("zero flag disagrees with result");

  // a full execute stage moves on or holds: a stalled output keeps it full
  a_exe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (exe_valid && out_ch.valid && !out_ch.ready) |=> exe_valid)
    else $error("execute stage item dropped under stall");

endmodule

### tb/two_operand_alu_with_flags_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_operand_alu_with_flags_core_test
// Self-checking bench for the two-operand ALU. Each instruction sent is run
// through a local model of the ALU and its flags, and the expected result is
// queued. Every result that comes back is checked field by field against the
// oldest entry. Directed corner cases come first, then random instructions
// under three patterns of idling on the request and result channels.
// ----------------------------------------------------------------------------
module two_operand_alu_with_flags_core_test;
  import toaf_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 10;

  logic clk;
  logic rst_n;

  toaf_in_if  in_ch ();
  toaf_out_if out_ch ();

  two_operand_alu_with_flags_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  res_t pending_results[$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Expected outcome of one instruction
  function automatic res_t alu_predict(input req_t rq);
    res_t        res;
    logic [15:0] msk, sgn, s, d, r, a_op;
    logic [16:0] sum;
    logic [4:0]  digit;
    logic        cin, c, v, upd, wr, dcy;
    int          ndig;
    msk  = rq.byte_mode ? MaskByte : MaskWord;
    sgn  = rq.byte_mode ? 16'h0080 : 16'h8000;
    s    = rq.src_value & msk;
    d    = rq.dst_value & msk;
    r    = d;
    c    = 1'b0;
    v    = 1'b0;
    upd  = 1'b1;
    wr   = 1'b1;
    case (opc_t'(rq.req_type))
      OPC_MOV: begin
        r   = s;
        upd = 1'b0;
      end
      OPC_ADD, OPC_ADDC, OPC_SUBC, OPC_SUB, OPC_CMP: begin
        if (rq.req_type == OPC_ADD || rq.req_type == OPC_ADDC) begin
          a_op = s;
        end else begin
          a_op = ~s & msk;
        end
        if (rq.req_type == OPC_ADD) begin
          cin = 1'b0;
        end else if (rq.req_type == OPC_ADDC || rq.req_type == OPC_SUBC) begin
          cin = rq.carry_in;
        end else begin
          cin = 1'b1;
        end
        sum = {1'b0, a_op} + {1'b0, d} + {16'd0, cin};
        r   = sum[15:0] & msk;
        c   = rq.byte_mode ? sum[8] : sum[16];
        v   = |((a_op ^ r) & (d ^ r) & sgn);
        if (rq.req_type == OPC_CMP) begin
          wr = 1'b0;
        end
      end
      OPC_DADD: begin
        // digit-wise decimal add; digits above nine still give a defined value
        ndig = rq.byte_mode ? 2 : 4;
        dcy  = rq.carry_in;
        r    = 16'h0000;
        for (int i = 0; i < ndig; i++) begin
          digit = {1'b0, s[4*i +: 4]} + {1'b0, d[4*i +: 4]} + {4'd0, dcy};
          if (digit >= 5'd10) begin
            digit = digit - 5'd10;
            dcy   = 1'b1;
          end else begin
            dcy = 1'b0;
          end
          r[4*i +: 4] = digit[3:0];
        end
        c = dcy;
      end
      OPC_BIT: begin
        r  = s & d;
        c  = |r;
        wr = 1'b0;
      end
      OPC_BIC: begin
        r   = ~s & d;
        upd = 1'b0;
      end
      OPC_BIS: begin
        r   = s | d;
        upd = 1'b0;
      end
      OPC_XOR: begin
        r = s ^ d;
        c = |r;
        v = |(s & d & sgn);
      end
      OPC_AND: begin
        r = s & d;
        c = |r;
      end
      default: begin
        upd = 1'b0;
        wr  = 1'b0;
      end
    endcase
    r = r & msk;
    res.result        = r;
    res.flag_negative = upd & |(r & sgn);
    res.flag_zero     = upd & (r == 16'h0000);
    res.flag_carry    = upd & c;
    res.flag_overflow = upd & v;
    res.flags_updated = upd;
    res.write_result  = wr;
    return res;
  endfunction

  task automatic send_item(input opc_t op, input logic bm, input logic [15:0] s,
                           input logic [15:0] d, input logic ci);
    req_t rq;
    rq.req_type  = op;
    rq.byte_mode = bm;
    rq.src_value = s;
    rq.dst_value = d;
    rq.carry_in  = ci;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= rq.req_type;
    in_ch.byte_mode <= rq.byte_mode;
    in_ch.src_value <= rq.src_value;
    in_ch.dst_value <= rq.dst_value;
    in_ch.carry_in  <= rq.carry_in;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_results.push_back(alu_predict(rq));
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin : result_check
    res_t want;
    res_t got;
    got.result        = out_ch.result;
    got.flag_negative = out_ch.flag_negative;
    got.flag_zero     = out_ch.flag_zero;
    got.flag_carry    = out_ch.flag_carry;
    got.flag_overflow = out_ch.flag_overflow;
    got.flags_updated = out_ch.flags_updated;
    got.write_result  = out_ch.write_result;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none actual %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        check_field("result", want.result, got.result);
        check_field("flag_negative", 16'(want.flag_negative), 16'(got.flag_negative));
        check_field("flag_zero", 16'(want.flag_zero), 16'(got.flag_zero));
        check_field("flag_carry", 16'(want.flag_carry), 16'(got.flag_carry));
        check_field("flag_overflow", 16'(want.flag_overflow), 16'(got.flag_overflow));
        check_field("flags_updated", 16'(want.flags_updated), 16'(got.flags_updated));
        check_field("write_result", 16'(want.write_result), 16'(got.write_result));
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("two_operand_alu_with_flags_core_test failed");
      $finish;
    end
  end

  // corner-heavy operand, BCD-shaped when asked
  function automatic logic [15:0] rand_operand(input bit bcd);
    logic [15:0] val;
    if (bcd) begin
      for (int i = 0; i < 4; i++) begin
        val[4*i +: 4] = 4'($urandom_range(9));
      end
      return val;
    end
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(7))
          0: val = 16'h0000;
          1: val = 16'hffff;
          2: val = 16'h7fff;
          3: val = 16'h8000;
          4: val = 16'h00ff;
          5: val = 16'h0080;
          6: val = 16'h007f;
          default: val = 16'hff00;
        endcase
      end
      default: val = 16'($urandom);
    endcase
    return val;
  endfunction

  task automatic test_logic_ops();
    send_item(OPC_MOV, 1'b0, 16'hffff, 16'h1234, 1'b1);
    send_item(OPC_MOV, 1'b1, 16'habcd, 16'hffff, 1'b0);
    send_item(OPC_BIC, 1'b0, 16'h0f0f, 16'hffff, 1'b1);
    send_item(OPC_BIS, 1'b1, 16'hff00, 16'h0000, 1'b0);
    send_item(OPC_XOR, 1'b0, 16'h8000, 16'h8000, 1'b0);
    send_item(OPC_XOR, 1'b1, 16'h0080, 16'hff80, 1'b1);
    send_item(OPC_AND, 1'b0, 16'hffff, 16'hffff, 1'b0);
    send_item(OPC_BIT, 1'b1, 16'h00f0, 16'h000f, 1'b1);
  endtask

  task automatic test_binary_arith();
    send_item(OPC_ADD,  1'b0, 16'h7fff, 16'h0001, 1'b1);
    send_item(OPC_ADD,  1'b0, 16'hffff, 16'h0001, 1'b0);
    send_item(OPC_ADD,  1'b1, 16'h007f, 16'hff01, 1'b0);
    send_item(OPC_ADDC, 1'b0, 16'hffff, 16'hffff, 1'b1);
    send_item(OPC_SUBC, 1'b0, 16'h0001, 16'h0000, 1'b0);
    send_item(OPC_SUB,  1'b0, 16'h0001, 16'h8000, 1'b0);
    send_item(OPC_SUB,  1'b1, 16'h00ff, 16'hff00, 1'b1);
    send_item(OPC_CMP,  1'b0, 16'h1234, 16'h1234, 1'b0);
    send_item(OPC_CMP,  1'b1, 16'h0001, 16'h0080, 1'b1);
  endtask

  task automatic test_decimal_add();
    send_item(OPC_DADD, 1'b0, 16'h9999, 16'h0001, 1'b0);
    send_item(OPC_DADD, 1'b0, 16'h1234, 16'h5678, 1'b1);
    send_item(OPC_DADD, 1'b1, 16'h0099, 16'h0099, 1'b1);
    // digits above nine
    send_item(OPC_DADD, 1'b0, 16'hffff, 16'hffff, 1'b1);
    send_item(OPC_DADD, 1'b1, 16'h1234, 16'hab00, 1'b0);
  endtask

  task automatic test_random_mix(input int n_items);
    opc_t op;
    bit   bcd;
    for (int k = 0; k < n_items; k++) begin
      op  = opc_t'($urandom_range(15, 4));
      bcd = (op == OPC_DADD) && ($urandom_range(3) != 0);
      send_item(op, 1'($urandom), rand_operand(bcd), rand_operand(bcd), 1'($urandom));
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.req_type  <= OPC_MOV;
    in_ch.byte_mode <= 1'b0;
    in_ch.src_value <= 16'h0000;
    in_ch.dst_value <= 16'h0000;
    in_ch.carry_in  <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 36;
    recv_idle_pct = 81;
    test_logic_ops();
    test_binary_arith();
    test_decimal_add();
    test_random_mix(240);

    send_idle_pct = 81;
    recv_idle_pct = 36;
    test_random_mix(240);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(220);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // catch any stray transfer after the last expected one
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("two_operand_alu_with_flags_core_test passed");
    end else begin
      $display("two_operand_alu_with_flags_core_test failed");
    end
    $finish;
  end

endmodule
